// ----- src/proximity_zone_and_direction_latch_defines.svh -----
// Assertion macros shared by the proximity zone block.
`ifndef PROXIMITY_ZONE_AND_DIRECTION_LATCH_DEFINES_SVH
`define PROXIMITY_ZONE_AND_DIRECTION_LATCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PZDL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pzdl: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PZDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pzdl: next-cycle check failed");

`endif

// ----- src/pzdl_pkg.sv -----
`default_nettype none

package pzdl_pkg;

   localparam int DIRECTIONS    = 6;
   localparam int DIST_BITS     = 16;
   localparam int CNT_BITS      = 8;
   localparam int ZONE_BITS     = 2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_DATA_BITS = ((DIRECTIONS + 1) * DIST_BITS + 7) / 8 * 8;
   localparam int RSP_DATA_BITS = ((ZONE_BITS + DIRECTIONS) + 7) / 8 * 8;

   typedef logic [DIST_BITS-1:0]  dist_type;
   typedef logic [DIST_BITS:0]    sum_type;
   typedef logic [CNT_BITS-1:0]   count_type;
   typedef logic [DIRECTIONS-1:0] mask_type;

   typedef enum logic [ZONE_BITS-1:0] {
      ZONE_SAFE = 2'd0,
      ZONE_SLOW = 2'd1,
      ZONE_STOP = 2'd2
   } zone_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_STOP_CM       = 3'd0,
      CSR_SLOW_CM       = 3'd1,
      CSR_ZONE_HYST_CM  = 3'd2,
      CSR_LATCH_HYST_CM = 3'd3,
      CSR_CLEAR_FRAMES  = 3'd4,
      CSR_LATCH_ENABLE  = 3'd5
   } csr_index_type;

   localparam dist_type  RST_STOP_CM       = 16'd100;
   localparam dist_type  RST_SLOW_CM       = 16'd300;
   localparam dist_type  RST_ZONE_HYST_CM  = 16'd50;
   localparam dist_type  RST_LATCH_HYST_CM = 16'd50;
   localparam count_type RST_CLEAR_FRAMES  = 8'd3;
   localparam logic      RST_LATCH_ENABLE  = 1'b1;
   localparam count_type CNT_MAX           = {CNT_BITS{1'b1}};
   localparam mask_type  ALL_DIRS          = {DIRECTIONS{1'b1}};

   typedef struct packed {
      dist_type  stop;
      dist_type  slow;
      sum_type   stop_out;
      sum_type   slow_out;
      count_type needed;
   } zone_cfg_type;

   typedef struct packed {
      dist_type  stop;
      sum_type   release_cm;
      count_type needed;
      logic      enable;
   } lane_cfg_type;

   // Saturating increment of a clear counter.
   function automatic count_type sat_inc(input count_type c);
      count_type r;
      r = (c == CNT_MAX) ? CNT_MAX : c + count_type'(1);
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/proximity_zone_and_direction_latch.sv -----
// Proximity zone machine with six per-direction stop-line latches.
// Input channel req_*: one range frame per item, nearest distance and six
// per-direction distances in tdata (0 means no obstacle), failsafe in tuser.
// Result channel rsp_*: one item per frame, zone code and latch mask.
// Configuration port csr_*: one register written per cycle at csr_wen;
// write only while no frame is in flight.
// Throughput: one frame per cycle while req_tready is high. Zone machine and six
// latch lanes all evaluate their compares and counter updates in the accept
// cycle, so the state feedback loop closes within the accept cycle.
// On accept the result goes into the output register, or into the skid stage if that register is full and not popped.
// Stall: while rsp_tready is low the output register holds its item and a
// skid stage takes one more; req_tready drops only when both are full.
// Reset: zone SAFE, all latches and clear counters zero, registers back
// to their defaults (stop 100, slow 300, hysteresis 50/50, 3 frames,
// latching on); output channel empty.
`default_nettype none

`include "proximity_zone_and_direction_latch_defines.svh"

module proximity_zone_and_direction_latch (
   input  wire                                     clock,
   input  wire                                     reset,
   // nearest_cm, fwd_cm, back_cm, right_cm, left_cm, down_cm, up_cm
   input  wire [pzdl_pkg::REQ_DATA_BITS-1:0]       req_tdata,
   // failsafe
   input  wire                                     req_tuser,
   input  wire                                     req_tvalid,
   output logic                                    req_tready,
   // zone[1:0], latch_mask[7:2]
   output logic [pzdl_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire                                     rsp_tready,
   input  wire                                     csr_wen,
   input  wire [pzdl_pkg::CSR_ADDR_BITS-1:0]       csr_addr,
   input  wire [pzdl_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int DB = pzdl_pkg::DIST_BITS;

   pzdl_pkg::dist_type  stop_ff, slow_ff, zone_hyst_ff, latch_hyst_ff;
   pzdl_pkg::count_type clear_frames_ff;
   logic                latch_enable_ff;

   pzdl_pkg::zone_cfg_type zone_cfg;
   pzdl_pkg::lane_cfg_type lane_cfg;
   pzdl_pkg::count_type    needed;
   pzdl_pkg::zone_type     zone_state, next_zone;
   pzdl_pkg::mask_type     latched, next_latched;
   logic                   accept;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff         <= pzdl_pkg::RST_STOP_CM;
         slow_ff         <= pzdl_pkg::RST_SLOW_CM;
         zone_hyst_ff    <= pzdl_pkg::RST_ZONE_HYST_CM;
         latch_hyst_ff   <= pzdl_pkg::RST_LATCH_HYST_CM;
         clear_frames_ff <= pzdl_pkg::RST_CLEAR_FRAMES;
         latch_enable_ff <= pzdl_pkg::RST_LATCH_ENABLE;
      end else if (csr_wen) begin
         unique case (csr_addr)
            pzdl_pkg::CSR_STOP_CM:       stop_ff         <= csr_wdata[DB-1:0];
            pzdl_pkg::CSR_SLOW_CM:       slow_ff         <= csr_wdata[DB-1:0];
            pzdl_pkg::CSR_ZONE_HYST_CM:  zone_hyst_ff    <= csr_wdata[DB-1:0];
            pzdl_pkg::CSR_LATCH_HYST_CM: latch_hyst_ff   <= csr_wdata[DB-1:0];
            pzdl_pkg::CSR_CLEAR_FRAMES:  clear_frames_ff <= csr_wdata[pzdl_pkg::CNT_BITS-1:0];
            pzdl_pkg::CSR_LATCH_ENABLE:  latch_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Derived thresholds, summed one bit wider so they never wrap
   always_comb begin
      needed = (clear_frames_ff == '0) ? pzdl_pkg::count_type'(1) : clear_frames_ff;
      zone_cfg.stop       = stop_ff;
      zone_cfg.slow       = slow_ff;
      zone_cfg.stop_out   = {1'b0, stop_ff} + {1'b0, zone_hyst_ff};
      zone_cfg.slow_out   = {1'b0, slow_ff} + {1'b0, zone_hyst_ff};
      zone_cfg.needed     = needed;
      lane_cfg.stop       = stop_ff;
      lane_cfg.release_cm = {1'b0, stop_ff} + {1'b0, latch_hyst_ff};
      lane_cfg.needed     = needed;
      lane_cfg.enable     = latch_enable_ff;
   end

   assign accept = req_tvalid && req_tready;

   pzdl_zone u_zone (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .failsafe   (req_tuser),
      .nearest    (req_tdata[DB-1:0]),
      .cfg        (zone_cfg),
      .zone_state (zone_state),
      .next_zone  (next_zone)
   );

   // One latch lane per direction
   for (genvar g = 0; g < pzdl_pkg::DIRECTIONS; g++) begin : g_lane
      pzdl_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .accept       (accept),
         .failsafe     (req_tuser),
         .dist_cm      (req_tdata[(g+2)*DB-1 -: DB]),
         .cfg          (lane_cfg),
         .latched      (latched[g]),
         .next_latched (next_latched[g])
      );
   end

   pzdl_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .zone       (next_zone),
      .mask       (next_latched),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `PZDL_ASSERT_NEXT(a_failsafe_stop, clock, reset, accept && req_tuser, zone_state == pzdl_pkg::ZONE_STOP)
   `PZDL_ASSERT_NEXT(a_failsafe_latch, clock, reset, accept && req_tuser && latch_enable_ff, latched == pzdl_pkg::ALL_DIRS)
   `PZDL_ASSERT_NEXT(a_disabled_clear, clock, reset, accept && !req_tuser && !latch_enable_ff, latched == '0)
   `PZDL_ASSERT_IMP(a_empty_ready, clock, reset, !rsp_tvalid, req_tready)

endmodule

`default_nettype wire

// ----- src/pzdl_zone.sv -----
`default_nettype none

module pzdl_zone (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire                    failsafe,
   input  wire pzdl_pkg::dist_type     nearest,
   input  wire pzdl_pkg::zone_cfg_type cfg,
   output pzdl_pkg::zone_type          zone_state,
   output pzdl_pkg::zone_type          next_zone
);

   pzdl_pkg::zone_type  zone_ff, zone_in;
   pzdl_pkg::count_type count_ff, count_in, count_inc;
   logic has, inside_stop, inside_slow, beyond_stop_out, beyond_slow_out;

   // Classify the nearest distance against the thresholds
   always_comb begin
      has             = (nearest != '0);
      inside_stop     = has && (nearest < cfg.stop);
      inside_slow     = has && (nearest < cfg.slow);
      beyond_stop_out = !has || ({1'b0, nearest} >= cfg.stop_out);
      beyond_slow_out = !has || ({1'b0, nearest} >= cfg.slow_out);
      count_inc       = pzdl_pkg::sat_inc(count_ff);
   end

   // Next zone and clear count
   always_comb begin
      zone_in  = zone_ff;
      count_in = count_ff;
      if (failsafe) begin
         zone_in = pzdl_pkg::ZONE_STOP;
      end else begin
         unique case (zone_ff)
            pzdl_pkg::ZONE_STOP: begin
               if (beyond_stop_out) begin
                  if (count_inc >= cfg.needed) begin
                     zone_in  = beyond_slow_out ? pzdl_pkg::ZONE_SAFE : pzdl_pkg::ZONE_SLOW;
                     count_in = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end else begin
                  count_in = '0;
               end
            end
            pzdl_pkg::ZONE_SLOW: begin
               if (inside_stop) begin
                  zone_in = pzdl_pkg::ZONE_STOP;
               end else if (beyond_slow_out) begin
                  zone_in = pzdl_pkg::ZONE_SAFE;
               end
               count_in = '0;
            end
            default: begin
               if (inside_stop) begin
                  zone_in = pzdl_pkg::ZONE_STOP;
               end else if (inside_slow) begin
                  zone_in = pzdl_pkg::ZONE_SLOW;
               end else begin
                  zone_in = pzdl_pkg::ZONE_SAFE;
               end
               count_in = '0;
            end
         endcase
      end
   end

   // Advance state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff  <= pzdl_pkg::ZONE_SAFE;
         count_ff <= '0;
      end else if (accept) begin
         zone_ff  <= zone_in;
         count_ff <= count_in;
      end
   end

   assign zone_state = zone_ff;
   assign next_zone  = zone_in;

endmodule

`default_nettype wire

// ----- src/pzdl_lane.sv -----
`default_nettype none

module pzdl_lane (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire                    failsafe,
   input  wire pzdl_pkg::dist_type     dist_cm,
   input  wire pzdl_pkg::lane_cfg_type cfg,
   output logic                        latched,
   output logic                        next_latched
);

   logic                latched_ff, latched_in;
   pzdl_pkg::count_type count_ff, count_in, count_inc;
   logic in_stop, clear;

   // Compare this direction against the stop line and release line
   always_comb begin
      in_stop   = (dist_cm != '0) && (dist_cm < cfg.stop);
      clear     = (dist_cm == '0) || ({1'b0, dist_cm} >= cfg.release_cm);
      count_inc = pzdl_pkg::sat_inc(count_ff);
   end

   // Next latch bit and clear count
   always_comb begin
      latched_in = latched_ff;
      count_in   = count_ff;
      if (failsafe) begin
         if (cfg.enable) begin
            latched_in = 1'b1;
         end
      end else if (!cfg.enable) begin
         latched_in = 1'b0;
         count_in   = '0;
      end else if (in_stop) begin
         latched_in = 1'b1;
         count_in   = '0;
      end else if (latched_ff) begin
         if (clear) begin
            if (count_inc >= cfg.needed) begin
               latched_in = 1'b0;
               count_in   = '0;
            end else begin
               count_in = count_inc;
            end
         end else begin
            count_in = '0;
         end
      end
   end

   // Advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= 1'b0;
         count_ff   <= '0;
      end else if (accept) begin
         latched_ff <= latched_in;
         count_ff   <= count_in;
      end
   end

   assign latched      = latched_ff;
   assign next_latched = latched_in;

endmodule

`default_nettype wire

// ----- src/pzdl_merge.sv -----
`default_nettype none

module pzdl_merge (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      load,
   input  wire pzdl_pkg::zone_type                  zone,
   input  wire pzdl_pkg::mask_type                  mask,
   output logic                                     ready,
   output logic                                     rsp_tvalid,
   input  wire                                      rsp_tready,
   output logic [pzdl_pkg::RSP_DATA_BITS-1:0]       rsp_tdata
);

   localparam int PACK_BITS = pzdl_pkg::ZONE_BITS + pzdl_pkg::DIRECTIONS;

   logic [pzdl_pkg::RSP_DATA_BITS-1:0] packed_item;
   logic [pzdl_pkg::RSP_DATA_BITS-1:0] main_data_ff, skid_data_ff;
   logic main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic pop;

   // Pack zone in the low bits, then the lane mask
   always_comb begin
      packed_item                = '0;
      packed_item[PACK_BITS-1:0] = {mask, zone};
   end

   assign pop   = main_valid_ff && rsp_tready;
   assign ready = !skid_valid_ff;

   // Occupancy of the output register and skid stage
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (load) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
         end else begin
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold payloads; refill the output register from the skid stage on a pop
   always_ff @(posedge clock) begin
      if (load) begin
         if (!main_valid_ff || pop) begin
            main_data_ff <= packed_item;
         end else begin
            skid_data_ff <= packed_item;
         end
      end else if (pop && skid_valid_ff) begin
         main_data_ff <= skid_data_ff;
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;

   // Indexes outside the register map; writes to them must change nothing
   localparam logic [pzdl_pkg::CSR_ADDR_BITS-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [pzdl_pkg::CSR_ADDR_BITS-1:0] CSR_SPARE_B = 3'd7;

   localparam int IDLE_PCT        = 28;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_ITEMS     = 116;
   localparam int CALM_PHASE      = 3;
   localparam int NO_LATCH_PHASE  = 4;
   localparam int HOLD_OFF_AFTER  = 300;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int MAX_REPORTS     = 10;
   localparam int DIST_MAX        = (1 << pzdl_pkg::DIST_BITS) - 1;

   typedef logic [pzdl_pkg::CSR_ADDR_BITS-1:0] csr_addr_type;
   typedef logic [pzdl_pkg::CSR_DATA_BITS-1:0] csr_data_type;

   typedef struct {
      pzdl_pkg::dist_type nearest;
      pzdl_pkg::dist_type dir_cm [pzdl_pkg::DIRECTIONS];
      logic               failsafe;
   } range_frame_type;

   typedef struct {
      pzdl_pkg::zone_type zone;
      pzdl_pkg::mask_type mask;
   } zone_report_type;

   // Zone and latch tracker plus the queue of results still owed by the block
   class zone_scoreboard;
      pzdl_pkg::dist_type  stop_cm;
      pzdl_pkg::dist_type  slow_cm;
      pzdl_pkg::dist_type  zone_hyst_cm;
      pzdl_pkg::dist_type  latch_hyst_cm;
      pzdl_pkg::count_type clear_frames;
      logic                latch_en;
      pzdl_pkg::zone_type  zone;
      pzdl_pkg::count_type stop_clear;
      pzdl_pkg::mask_type  latched;
      pzdl_pkg::count_type lane_clear [pzdl_pkg::DIRECTIONS];
      zone_report_type     pending_reports [$];
      int                  checked;
      int                  mismatches;

      function new();
         stop_cm       = pzdl_pkg::RST_STOP_CM;
         slow_cm       = pzdl_pkg::RST_SLOW_CM;
         zone_hyst_cm  = pzdl_pkg::RST_ZONE_HYST_CM;
         latch_hyst_cm = pzdl_pkg::RST_LATCH_HYST_CM;
         clear_frames  = pzdl_pkg::RST_CLEAR_FRAMES;
         latch_en      = pzdl_pkg::RST_LATCH_ENABLE;
         zone          = pzdl_pkg::ZONE_SAFE;
         stop_clear    = '0;
         latched       = '0;
         foreach (lane_clear[i]) lane_clear[i] = '0;
         checked       = 0;
         mismatches    = 0;
      endfunction

      function void write_reg(csr_addr_type idx, csr_data_type value);
         case (idx)
            pzdl_pkg::CSR_STOP_CM:       stop_cm       = value[pzdl_pkg::DIST_BITS-1:0];
            pzdl_pkg::CSR_SLOW_CM:       slow_cm       = value[pzdl_pkg::DIST_BITS-1:0];
            pzdl_pkg::CSR_ZONE_HYST_CM:  zone_hyst_cm  = value[pzdl_pkg::DIST_BITS-1:0];
            pzdl_pkg::CSR_LATCH_HYST_CM: latch_hyst_cm = value[pzdl_pkg::DIST_BITS-1:0];
            pzdl_pkg::CSR_CLEAR_FRAMES:  clear_frames  = value[pzdl_pkg::CNT_BITS-1:0];
            pzdl_pkg::CSR_LATCH_ENABLE:  latch_en      = value[0];
            default: ;
         endcase
      endfunction

      function pzdl_pkg::count_type frames_needed();
         return (clear_frames == '0) ? pzdl_pkg::count_type'(1) : clear_frames;
      endfunction

      // Clear counters stick at their top value
      function pzdl_pkg::count_type bump(pzdl_pkg::count_type c);
         return (c == {pzdl_pkg::CNT_BITS{1'b1}}) ? c : c + pzdl_pkg::count_type'(1);
      endfunction

      // Advance the zone machine and the latches by one frame, queue the result
      function void note_frame(range_frame_type f);
         zone_report_type    r;
         pzdl_pkg::sum_type  near_w;
         pzdl_pkg::sum_type  stop_out;
         pzdl_pkg::sum_type  slow_out;
         pzdl_pkg::sum_type  release_cm;
         logic               has;
         pzdl_pkg::mask_type bit_m;
         if (f.failsafe) begin
            zone = pzdl_pkg::ZONE_STOP;
            if (latch_en) latched = pzdl_pkg::ALL_DIRS;
         end else begin
            has        = f.nearest != '0;
            near_w     = {1'b0, f.nearest};
            stop_out   = {1'b0, stop_cm} + {1'b0, zone_hyst_cm};
            slow_out   = {1'b0, slow_cm} + {1'b0, zone_hyst_cm};
            release_cm = {1'b0, stop_cm} + {1'b0, latch_hyst_cm};
            case (zone)
               pzdl_pkg::ZONE_STOP: begin
                  if (!has || near_w >= stop_out) begin
                     stop_clear = bump(stop_clear);
                     if (stop_clear >= frames_needed()) begin
                        if (!has || near_w >= slow_out) zone = pzdl_pkg::ZONE_SAFE;
                        else zone = pzdl_pkg::ZONE_SLOW;
                        stop_clear = '0;
                     end
                  end else begin
                     stop_clear = '0;
                  end
               end
               pzdl_pkg::ZONE_SLOW: begin
                  if (has && f.nearest < stop_cm) zone = pzdl_pkg::ZONE_STOP;
                  else if (!has || near_w >= slow_out) zone = pzdl_pkg::ZONE_SAFE;
                  stop_clear = '0;
               end
               default: begin
                  if (has && f.nearest < stop_cm) zone = pzdl_pkg::ZONE_STOP;
                  else if (has && f.nearest < slow_cm) zone = pzdl_pkg::ZONE_SLOW;
                  else zone = pzdl_pkg::ZONE_SAFE;
                  stop_clear = '0;
               end
            endcase
            // Latch lanes: set inside stop, release after enough clear frames
            if (!latch_en) begin
               latched = '0;
               foreach (lane_clear[i]) lane_clear[i] = '0;
            end else begin
               for (int i = 0; i < pzdl_pkg::DIRECTIONS; i++) begin
                  bit_m = pzdl_pkg::mask_type'(1) << i;
                  if (f.dir_cm[i] != '0 && f.dir_cm[i] < stop_cm) begin
                     latched       = latched | bit_m;
                     lane_clear[i] = '0;
                  end else if ((latched & bit_m) != '0) begin
                     if (f.dir_cm[i] == '0 || {1'b0, f.dir_cm[i]} >= release_cm) begin
                        lane_clear[i] = bump(lane_clear[i]);
                        if (lane_clear[i] >= frames_needed()) begin
                           latched       = latched & ~bit_m;
                           lane_clear[i] = '0;
                        end
                     end else begin
                        lane_clear[i] = '0;
                     end
                  end
               end
            end
         end
         r.zone = zone;
         r.mask = latched;
         pending_reports.push_back(r);
      endfunction

      // Compare one result item with the oldest queued one
      function void check_result(logic [pzdl_pkg::RSP_DATA_BITS-1:0] data);
         zone_report_type                want;
         logic [pzdl_pkg::ZONE_BITS-1:0] got_zone;
         pzdl_pkg::mask_type             got_mask;
         got_zone = data[pzdl_pkg::ZONE_BITS-1:0];
         got_mask = data[pzdl_pkg::ZONE_BITS +: pzdl_pkg::DIRECTIONS];
         checked++;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d arrived with nothing queued: zone=%0d mask=%b",
                        checked, got_zone, got_mask);
            return;
         end
         want = pending_reports.pop_front();
         if (got_zone !== want.zone || got_mask !== want.mask) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d: zone exp %0d got %0d, mask exp %b got %b",
                        checked, want.zone, got_zone, want.mask, got_mask);
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic [pzdl_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic                               req_tuser;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [pzdl_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic                               csr_wen;
   csr_addr_type                       csr_addr;
   csr_data_type                       csr_wdata;

   zone_scoreboard sb = new();
   bit             calm = 1'b0;
   int             clear_run = 0;

   proximity_zone_and_direction_latch i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   function automatic range_frame_type make_frame(int nearest, int dir_val,
                                                  pzdl_pkg::mask_type dirs, logic fs);
      range_frame_type f;
      f.nearest = pzdl_pkg::dist_type'(nearest);
      for (int i = 0; i < pzdl_pkg::DIRECTIONS; i++)
         f.dir_cm[i] = dirs[i] ? pzdl_pkg::dist_type'(dir_val) : '0;
      f.failsafe = fs;
      return f;
   endfunction

   // Distance drawn around the current thresholds, or far enough to count as clear
   function automatic pzdl_pkg::dist_type pick_dist(bit far_only);
      int stop_i;
      int slow_i;
      int zh_i;
      int lh_i;
      int lo;
      int v;
      int sel;
      stop_i = sb.stop_cm;
      slow_i = sb.slow_cm;
      zh_i   = sb.zone_hyst_cm;
      lh_i   = sb.latch_hyst_cm;
      if (far_only) begin
         lo = stop_i + lh_i;
         if (stop_i + zh_i > lo) lo = stop_i + zh_i;
         if (slow_i + zh_i > lo) lo = slow_i + zh_i;
         if (lo > DIST_MAX || $urandom_range(3) == 0) return '0;
         return pzdl_pkg::dist_type'($urandom_range(DIST_MAX, lo));
      end
      sel = $urandom_range(99);
      if (sel < 12) return '0;
      if (sel < 40) v = stop_i - 3 + int'($urandom_range(lh_i + zh_i + 6));
      else if (sel < 65) v = slow_i - 3 + int'($urandom_range(zh_i + 6));
      else if (sel < 78) v = int'($urandom_range(8, 1));
      else v = int'($urandom_range(DIST_MAX));
      if (v < 0) v = 0;
      if (v > DIST_MAX) v = DIST_MAX;
      return pzdl_pkg::dist_type'(v);
   endfunction

   // Mostly approach and retreat episodes: bursts of clear frames long enough to release
   function automatic range_frame_type random_frame();
      range_frame_type f;
      bit              far;
      if (clear_run == 0 && $urandom_range(99) < 15)
         clear_run = int'(sb.frames_needed()) + int'($urandom_range(2));
      far = clear_run > 0;
      if (far) clear_run--;
      f.failsafe = !far && $urandom_range(99) < 3;
      f.nearest  = pick_dist(far);
      for (int i = 0; i < pzdl_pkg::DIRECTIONS; i++)
         f.dir_cm[i] = ($urandom_range(3) == 0) ? pzdl_pkg::dist_type'(0) : pick_dist(far);
      return f;
   endfunction

   // Offer one item and hold it until the block takes it
   task automatic send_frame(range_frame_type f);
      logic [pzdl_pkg::REQ_DATA_BITS-1:0] data;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      data = '0;
      data[pzdl_pkg::DIST_BITS-1:0] = f.nearest;
      for (int i = 0; i < pzdl_pkg::DIRECTIONS; i++)
         data[pzdl_pkg::DIST_BITS*(i+1) +: pzdl_pkg::DIST_BITS] = f.dir_cm[i];
      req_tdata  <= data;
      req_tuser  <= f.failsafe;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_frame(f);
   endtask

   // Drop valid and wait until every queued result has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(csr_addr_type idx, csr_data_type value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   // Write the whole register set; narrow registers get junk in their upper bits
   task automatic set_config(int stop, int slow, int zh, int lh, int cf, bit le);
      wait_idle();
      write_csr(CSR_SPARE_A, csr_data_type'($urandom));
      write_csr(pzdl_pkg::CSR_STOP_CM, csr_data_type'(stop));
      write_csr(pzdl_pkg::CSR_SLOW_CM, csr_data_type'(slow));
      write_csr(pzdl_pkg::CSR_ZONE_HYST_CM, csr_data_type'(zh));
      write_csr(pzdl_pkg::CSR_LATCH_HYST_CM, csr_data_type'(lh));
      write_csr(pzdl_pkg::CSR_CLEAR_FRAMES,
                csr_data_type'(cf | ($urandom_range(255) << 8)));
      write_csr(pzdl_pkg::CSR_LATCH_ENABLE,
                csr_data_type'(le | ($urandom_range(32767) << 1)));
      write_csr(CSR_SPARE_B, csr_data_type'($urandom));
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: check accepted items, stall at random, one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && sb.checked >= HOLD_OFF_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Stimulus: directed frames at reset settings, then random phases
   initial begin
      int stop;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tvalid <= 1'b0;
      csr_wen    <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zone bands and hysteresis
      send_frame(make_frame(0, 0, '0, 1'b0));
      send_frame(make_frame(250, 0, '0, 1'b0));
      send_frame(make_frame(320, 0, '0, 1'b0));
      send_frame(make_frame(350, 0, '0, 1'b0));
      send_frame(make_frame(299, 0, '0, 1'b0));
      // Enter stop, marginal frames reset the clear counts, then release
      send_frame(make_frame(99, 99, 6'h01, 1'b0));
      send_frame(make_frame(120, 120, 6'h01, 1'b0));
      send_frame(make_frame(150, 150, 6'h01, 1'b0));
      send_frame(make_frame(120, 120, 6'h01, 1'b0));
      repeat (3) send_frame(make_frame(0, 0, '0, 1'b0));
      // All lanes latched, release into the slow band
      send_frame(make_frame(1, 1, pzdl_pkg::ALL_DIRS, 1'b0));
      send_frame(make_frame(DIST_MAX, DIST_MAX, pzdl_pkg::ALL_DIRS, 1'b0));
      send_frame(make_frame(200, 0, '0, 1'b0));
      send_frame(make_frame(200, 0, '0, 1'b0));
      send_frame(make_frame(100, 100, pzdl_pkg::ALL_DIRS, 1'b0));
      // Failsafe ignores the distances
      send_frame(make_frame(DIST_MAX, DIST_MAX, pzdl_pkg::ALL_DIRS, 1'b1));
      send_frame(make_frame(0, 0, '0, 1'b1));
      send_frame(make_frame(16'hAAAA, 16'h5555, pzdl_pkg::ALL_DIRS, 1'b0));
      send_frame(make_frame(16'h5555, 16'hAAAA, pzdl_pkg::ALL_DIRS, 1'b0));
      send_frame(make_frame(50, 60, 6'h2A, 1'b0));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         stop = int'($urandom_range(2000, 20));
         case (p)
            0: set_config(100, 300, 50, 50, 3, 1'b1);
            1: set_config(0, 0, 0, 0, 0, 1'b1);
            2: set_config(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, 255, 1'b1);
            NO_LATCH_PHASE:
               set_config(stop, stop + int'($urandom_range(3000)), int'($urandom_range(500)),
                          int'($urandom_range(500)), int'($urandom_range(6)), 1'b0);
            default:
               set_config(stop, stop + int'($urandom_range(3000)), int'($urandom_range(500)),
                          int'($urandom_range(500)), int'($urandom_range(6)), 1'b1);
         endcase
         calm      = (p == CALM_PHASE);
         clear_run = 0;
         repeat (PHASE_ITEMS) send_frame(random_frame());
      end
      calm = 1'b0;

      wait_idle();
      if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- proximity_zone_and_direction_latch.f -----
+incdir+src
src/pzdl_pkg.sv
src/pzdl_zone.sv
src/pzdl_lane.sv
src/pzdl_merge.sv
src/proximity_zone_and_direction_latch.sv
verif/tb_top.sv
